// ===== rtl/core/png_text_chunk_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// PNG tEXt chunk extractor assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PNG_TEXT_CHUNK_EXTRACTOR_ASSERT_SVH
`define PNG_TEXT_CHUNK_EXTRACTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNGTXT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNGTXT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pngtxt_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG tEXt chunk extractor package
// Shared types, codes and constants of the extractor.
// ----------------------------------------------------------------------------
package pngtxt_pkg;

	localparam int MAX_VALUE_DEF = 64;
	localparam int KEY_MAX       = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int KEY_LEN_W     = 5;

	localparam logic [31:0] TYPE_IEND = 32'h49454E44;
	localparam logic [31:0] TYPE_TEXT = 32'h74455874;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LOW  = 2'd0,
		CFG_KEY_HIGH = 2'd1,
		CFG_KEY_LEN  = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_DATA,
		PH_CRC,
		PH_IDLE
	} parse_phase_t;

	typedef enum logic [1:0] {
		ST_PARSE,
		ST_READ,
		ST_LOAD
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} png_in_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       found;
		logic       truncated;
		logic       last_in_run;
	} png_out_t;

	typedef struct packed {
		logic accept;
		logic rd_issue;
		logic out_load_run;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic run_start;
		logic run_last;
	} dp_sts_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			default: b = 8'h0A;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/pngtxt_ram.sv =====
// ----------------------------------------------------------------------------
// PNG tEXt chunk extractor RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pngtxt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/pngtxt_ctrl.sv =====
// ----------------------------------------------------------------------------
// PNG tEXt chunk extractor controller
// Sequences byte intake and the read-out of a buffered value.
// ----------------------------------------------------------------------------
module pngtxt_ctrl
	import pngtxt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    file_valid,
	output logic    file_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PARSE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_PARSE: begin
				if (file_valid && sts.out_free && sts.run_start) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					state_nxt = sts.run_last ? ST_PARSE : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_PARSE;
			end
		endcase
	end

	always_comb begin
		file_ready       = 1'b0;
		cmd.accept       = 1'b0;
		cmd.rd_issue     = 1'b0;
		cmd.out_load_run = 1'b0;
		case (state_q)
			ST_PARSE: begin
				file_ready = sts.out_free;
				cmd.accept = file_valid && sts.out_free;
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
			end
			ST_LOAD: begin
				cmd.out_load_run = sts.out_free;
			end
			default: begin
				file_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/pngtxt_dp.sv =====
// ----------------------------------------------------------------------------
// PNG tEXt chunk extractor datapath
// Chunk parser state, keyword compare, value buffer and result register.
// ----------------------------------------------------------------------------
module pngtxt_dp
	import pngtxt_pkg::*;
#(
	parameter int MAX_VALUE = MAX_VALUE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  png_in_t               file_item,
	input  logic                  result_ready,
	output logic                  result_valid,
	output png_out_t              result_item,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts
);

	localparam int AW = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
	localparam int CW = $clog2(MAX_VALUE + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VALUE);
	localparam logic [KEY_LEN_W-1:0] KEY_LIM = KEY_LEN_W'(KEY_MAX);
	localparam logic [KEY_LEN_W-1:0] POS_LIM = '1;

	logic [63:0]          key_lo_q;
	logic [63:0]          key_hi_q;
	logic [KEY_LEN_W-1:0] key_len_q;

	parse_phase_t         phase_q,  phase_nxt;
	logic [31:0]          fc_q,     fc_nxt;
	logic [31:0]          len_q,    len_nxt;
	logic [31:0]          type_q,   type_nxt;
	logic [KEY_LEN_W-1:0] pos_q,    pos_nxt;
	logic                 match_q,  match_nxt;
	logic                 sep_q,    sep_nxt;
	logic [CW-1:0]        count_q,  count_nxt;
	logic                 ovf_q,    ovf_nxt;
	logic                 search_q, search_nxt;

	logic [CW-1:0]        run_len_s1;
	logic                 run_trunc_s1;
	logic [AW-1:0]        run_idx_q;
	logic                 result_valid_q;
	png_out_t             result_q;

	logic [7:0]           b;
	logic [KEY_LEN_W-1:0] klen;
	logic [127:0]         key_vec;
	logic [7:0]           key_b;
	logic [31:0]          fc_p1;
	logic [31:0]          type_shift;
	logic                 emit_found;
	logic                 emit_single;
	logic                 buf_we;
	logic [7:0]           rdata;
	logic [AW:0]          idx_p1;

	assign b       = file_item.data_byte;
	assign klen    = (key_len_q > KEY_LIM) ? KEY_LIM : key_len_q;
	assign key_vec = {key_hi_q, key_lo_q};
	assign key_b   = key_vec[pos_q[3:0]*8 +: 8];
	assign fc_p1   = fc_q + 32'd1;
	assign type_shift = {type_q[23:0], b};

	always_comb begin
		phase_nxt  = phase_q;
		fc_nxt     = fc_q;
		len_nxt    = len_q;
		type_nxt   = type_q;
		pos_nxt    = pos_q;
		match_nxt  = match_q;
		sep_nxt    = sep_q;
		count_nxt  = count_q;
		ovf_nxt    = ovf_q;
		search_nxt = search_q;
		emit_found = 1'b0;
		buf_we     = 1'b0;
		case (phase_q)
			PH_SIG: begin
				if (b != sig_byte(fc_q[2:0])) begin
					phase_nxt = PH_IDLE;
				end else if (fc_q[2:0] == 3'd7) begin
					fc_nxt    = '0;
					phase_nxt = PH_LEN;
				end else begin
					fc_nxt = fc_p1;
				end
			end
			PH_LEN: begin
				len_nxt = {len_q[23:0], b};
				if (fc_q[1:0] == 2'd3) begin
					fc_nxt    = '0;
					phase_nxt = PH_TYPE;
				end else begin
					fc_nxt = fc_p1;
				end
			end
			PH_TYPE: begin
				type_nxt = type_shift;
				if (fc_q[1:0] == 2'd3) begin
					fc_nxt = '0;
					if (type_shift == TYPE_IEND) begin
						phase_nxt = PH_IDLE;
					end else begin
						pos_nxt   = '0;
						match_nxt = 1'b1;
						sep_nxt   = 1'b0;
						count_nxt = '0;
						ovf_nxt   = 1'b0;
						phase_nxt = (len_q == 32'd0) ? PH_CRC : PH_DATA;
					end
				end else begin
					fc_nxt = fc_p1;
				end
			end
			PH_DATA: begin
				if (type_q == TYPE_TEXT) begin
					if (!sep_q) begin
						if (b == 8'd0) begin
							sep_nxt = 1'b1;
							if (pos_q != klen) begin
								match_nxt = 1'b0;
							end
						end else begin
							if (!(pos_q < klen && b == key_b)) begin
								match_nxt = 1'b0;
							end
							if (pos_q != POS_LIM) begin
								pos_nxt = pos_q + KEY_LEN_W'(1);
							end
						end
					end else if (count_q < COUNT_MAX) begin
						buf_we    = 1'b1;
						count_nxt = count_q + CW'(1);
					end else begin
						ovf_nxt = 1'b1;
					end
				end
				if (fc_p1 == len_q) begin
					fc_nxt    = '0;
					phase_nxt = PH_CRC;
				end else begin
					fc_nxt = fc_p1;
				end
			end
			PH_CRC: begin
				if (fc_q[1:0] == 2'd3) begin
					fc_nxt = '0;
					if (type_q == TYPE_TEXT && sep_q && match_q) begin
						emit_found = 1'b1;
						search_nxt = 1'b1;
						phase_nxt  = PH_IDLE;
					end else begin
						phase_nxt = PH_LEN;
					end
				end else begin
					fc_nxt = fc_p1;
				end
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase
		if (file_item.end_of_file) begin
			phase_nxt  = PH_SIG;
			fc_nxt     = '0;
			len_nxt    = '0;
			type_nxt   = '0;
			pos_nxt    = '0;
			match_nxt  = 1'b1;
			sep_nxt    = 1'b0;
			count_nxt  = '0;
			ovf_nxt    = 1'b0;
			search_nxt = 1'b0;
		end
	end

	assign emit_single = (emit_found && count_q == '0) ||
		(file_item.end_of_file && !search_q && !emit_found);

	assign idx_p1        = {1'b0, run_idx_q} + (AW+1)'(1);
	assign sts.out_free  = !result_valid_q || result_ready;
	assign sts.run_start = emit_found && count_q != '0;
	assign sts.run_last  = idx_p1 == (AW+1)'(run_len_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KEY_LOW:  key_lo_q  <= cfg_data;
				CFG_KEY_HIGH: key_hi_q  <= cfg_data;
				CFG_KEY_LEN:  key_len_q <= cfg_data[KEY_LEN_W-1:0];
				default:      key_len_q <= key_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIG;
			fc_q      <= '0;
			len_q     <= '0;
			type_q    <= '0;
			pos_q     <= '0;
			match_q   <= 1'b1;
			sep_q     <= 1'b0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			search_q  <= 1'b0;
			run_idx_q <= '0;
		end else begin
			if (cmd.accept) begin
				phase_q  <= phase_nxt;
				fc_q     <= fc_nxt;
				len_q    <= len_nxt;
				type_q   <= type_nxt;
				pos_q    <= pos_nxt;
				match_q  <= match_nxt;
				sep_q    <= sep_nxt;
				count_q  <= count_nxt;
				ovf_q    <= ovf_nxt;
				search_q <= search_nxt;
			end
			if (cmd.accept && sts.run_start) begin
				run_idx_q <= '0;
			end else if (cmd.out_load_run) begin
				run_idx_q <= idx_p1[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.run_start) begin
			run_len_s1   <= count_q;
			run_trunc_s1 <= ovf_q;
		end
	end

	pngtxt_ram #(
		.WIDTH (8),
		.DEPTH (MAX_VALUE)
	) u_value_buf (
		.clk   (clk),
		.we    (cmd.accept && buf_we),
		.waddr (count_q[AW-1:0]),
		.wdata (b),
		.re    (cmd.rd_issue),
		.raddr (run_idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load_run || (cmd.accept && emit_single)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_run) begin
			result_q.value_byte  <= rdata;
			result_q.byte_valid  <= 1'b1;
			result_q.found       <= 1'b1;
			result_q.truncated   <= run_trunc_s1;
			result_q.last_in_run <= sts.run_last;
		end else if (cmd.accept && emit_single) begin
			result_q.value_byte  <= '0;
			result_q.byte_valid  <= 1'b0;
			result_q.found       <= emit_found;
			result_q.truncated   <= 1'b0;
			result_q.last_in_run <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

// ===== rtl/core/png_text_chunk_extractor.sv =====
// ----------------------------------------------------------------------------
// PNG tEXt chunk extractor
// Walks the chunks of a PNG byte stream and returns the text value of the
// tEXt chunk whose keyword matches the configured one.
//
//   Channel   Signals                                   Moves
//   file      file_valid, file_ready, file_item         one file byte
//   result    result_valid, result_ready, result_item   one value byte or flag
//   config    cfg_write, cfg_index, cfg_data            one register write
//
// One file byte is taken per cycle while the result register is free.
// The byte that closes a matching chunk holds intake while each value byte
// passes through the buffer RAM read followed by the result register load.
// Reset is asynchronous and clears the parser, controller and key registers.
// A stalled result register stops intake until the transaction completes.
// ----------------------------------------------------------------------------
`include "png_text_chunk_extractor_assert.svh"

module png_text_chunk_extractor
	import pngtxt_pkg::*;
#(
	parameter int MAX_VALUE = MAX_VALUE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  file_valid,
	output logic                  file_ready,
	input  png_in_t               file_item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output png_out_t              result_item
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	pngtxt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.file_ready (file_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	pngtxt_dp #(
		.MAX_VALUE (MAX_VALUE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.file_item    (file_item),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_item  (result_item),
		.cmd          (cmd),
		.sts          (sts)
	);

	`PNGTXT_ASSERT_SAME(a_intake_needs_free_out, clk, arst_n, file_valid && file_ready, !result_valid || result_ready, "Byte taken while a result was blocked.")
	`PNGTXT_ASSERT_SAME(a_run_blocks_intake, clk, arst_n, result_valid && !result_item.last_in_run, !file_ready, "Byte intake open in the middle of a value run.")
	`PNGTXT_ASSERT_SAME(a_flag_result_is_last, clk, arst_n, result_valid && !result_item.byte_valid, result_item.last_in_run && !result_item.truncated, "Flag-only result is not a single final transaction.")
	`PNGTXT_ASSERT_SAME(a_trunc_implies_found, clk, arst_n, result_valid && result_item.truncated, result_item.found && result_item.byte_valid, "Truncated result without a found value byte.")

endmodule
